>>> hdl/assert_macros.svh
// Assertion macros shared by the viseme timeline engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/vte_pkg.sv
// Package with the types, constants and lookup table of the viseme timeline engine.
`timescale 1ns / 1ps

package vte_pkg;

   localparam int FUNC_W     = 2;
   localparam int PHONEME_W  = 5;
   localparam int VIS_W      = 4;
   localparam int BLEND_W    = 4;
   localparam int FIDX_W     = 6;
   localparam int FCOUNT_W   = 7;
   localparam int PERIOD_W   = 10;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int OP_W       = 2;

   localparam int DEF_MAX_PHONEMES = 64;
   localparam int DEF_TIME_BITS    = 24;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd33;

   localparam logic [CSR_ADDR_W-3:0] REG_FRAME_PERIOD = 1'b0;

   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   localparam int DUR_SHORT_MS = 100;
   localparam int DUR_MID_MS   = 200;

   localparam logic [BLEND_W-1:0] BLEND_SHORT = 4'd8;
   localparam logic [BLEND_W-1:0] BLEND_MID   = 4'd5;
   localparam logic [BLEND_W-1:0] BLEND_LONG  = 4'd2;
   localparam logic [BLEND_W-1:0] BLEND_NONE  = 4'd0;

   localparam logic [VIS_W-1:0] VISEME_SIL = 4'd0;

   typedef enum logic [OP_W-1:0] {
      OP_ADD,
      OP_QUERY,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EMIT
   } back_state_type;

   localparam logic [VIS_W-1:0] VISEME_TABLE [32] = '{
      4'd0,  4'd0,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd1,
      4'd1,  4'd1,  4'd2,  4'd2,  4'd3,  4'd4,  4'd4,  4'd5,
      4'd5,  4'd5,  4'd8,  4'd9,  4'd7,  4'd7,  4'd14, 4'd0,
      4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0
   };

   function automatic logic [VIS_W-1:0] viseme_of(input logic [PHONEME_W-1:0] phoneme);
      return VISEME_TABLE[phoneme];
   endfunction

endpackage

>>> hdl/viseme_timeline_engine.sv
// Flow: an accepted word waits in the queue until the back end is idle and pops it;
// a query on a non-empty table then runs the one-entry-per-cycle table scan, and every
// result is registered at the output once it is free. No new word is popped until then;
// a 2-word queue lets the input side run ahead of the back end.
// Reset: frame and phoneme counts clear and the frame period returns to 33 ms;
// the frame table is not swept, its contents stay undefined until written.
`timescale 1ns / 1ps

module viseme_timeline_engine #(
   parameter int MAX_PHONEMES = vte_pkg::DEF_MAX_PHONEMES,
   parameter int TIME_BITS    = vte_pkg::DEF_TIME_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [vte_pkg::FUNC_W-1:0]      req_func,
   input  logic [vte_pkg::PHONEME_W-1:0]   req_phoneme,
   input  logic [TIME_BITS-1:0]            req_start_ms,
   input  logic [TIME_BITS-1:0]            req_end_ms,
   input  logic [TIME_BITS-1:0]            req_query_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_status,
   output logic [vte_pkg::FIDX_W-1:0]      rsp_frame_index,
   output logic                            rsp_merged,
   output logic [vte_pkg::VIS_W-1:0]       rsp_viseme,
   output logic [vte_pkg::BLEND_W-1:0]     rsp_blend_tenths,
   output logic [vte_pkg::FCOUNT_W-1:0]    rsp_frame_count,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [vte_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [vte_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [vte_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import vte_pkg::*;

   `include "assert_macros.svh"

   localparam int CMD_W = OP_W + VIS_W + 2 * TIME_BITS;

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic                csr_hit;
   logic [CMD_W-1:0]    front_cmd;
   logic [CMD_W-1:0]    q_data;
   logic                q_full;
   logic                q_valid;
   logic                q_pop;
   logic                q_push;
   logic                rsp_fields_idle;
   logic                rsp_merge_sane;
   logic                rsp_blend_legal;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_FRAME_PERIOD);
   assign csr_prdata = csr_hit ? CSR_DATA_W'(period_ff) : '0;

   always_comb begin
      period_in = period_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         period_in = csr_pwdata[PERIOD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   vte_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .func     (req_func),
      .phoneme  (req_phoneme),
      .start_ms (req_start_ms),
      .end_ms   (req_end_ms),
      .query_ms (req_query_ms),
      .cmd      (front_cmd)
   );

   vte_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_data)
   );

   vte_back #(
      .MAX_PHONEMES (MAX_PHONEMES),
      .TIME_BITS    (TIME_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .period           (period_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_frame_index  (rsp_frame_index),
      .rsp_merged       (rsp_merged),
      .rsp_viseme       (rsp_viseme),
      .rsp_blend_tenths (rsp_blend_tenths),
      .rsp_frame_count  (rsp_frame_count)
   );

   assign rsp_fields_idle = !rsp_merged && rsp_viseme == VISEME_SIL
                            && rsp_blend_tenths == BLEND_NONE;
   assign rsp_merge_sane  = !rsp_status && rsp_blend_tenths != BLEND_NONE
                            && rsp_frame_count != '0;
   assign rsp_blend_legal = rsp_blend_tenths == BLEND_NONE || rsp_blend_tenths == BLEND_SHORT
                            || rsp_blend_tenths == BLEND_MID || rsp_blend_tenths == BLEND_LONG;

   `ASSERT_IMPLIES(a_full_fields_zero, clock, reset, rsp_valid && rsp_status, rsp_fields_idle)
   `ASSERT_IMPLIES(a_merge_has_blend, clock, reset, rsp_valid && rsp_merged, rsp_merge_sane)
   `ASSERT_IMPLIES(a_blend_legal, clock, reset, rsp_valid, rsp_blend_legal)
   `ASSERT_NEXT(a_pop_frees_queue, clock, reset, q_pop && !q_push, !q_full)

endmodule

>>> hdl/vte_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module vte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/vte_front.sv
// Front end: decode the operation and map the phoneme to its viseme.
`timescale 1ns / 1ps

module vte_front #(
   parameter int TIME_BITS = vte_pkg::DEF_TIME_BITS,
   localparam int CMD_W    = vte_pkg::OP_W + vte_pkg::VIS_W + 2 * TIME_BITS
) (
   input  logic [vte_pkg::FUNC_W-1:0]    func,
   input  logic [vte_pkg::PHONEME_W-1:0] phoneme,
   input  logic [TIME_BITS-1:0]          start_ms,
   input  logic [TIME_BITS-1:0]          end_ms,
   input  logic [TIME_BITS-1:0]          query_ms,
   output logic [CMD_W-1:0]              cmd
);
   import vte_pkg::*;

   op_type                op;
   logic [VIS_W-1:0]      vis;
   logic [TIME_BITS-1:0]  time_a;

   always_comb begin
      case (func)
         FUNC_ADD:   op = OP_ADD;
         FUNC_QUERY: op = OP_QUERY;
         FUNC_CLEAR: op = OP_CLEAR;
         default:    op = OP_NONE;
      endcase
   end

   assign vis    = viseme_of(phoneme);
   assign time_a = (op == OP_QUERY) ? query_ms : start_ms;
   assign cmd    = {op, vis, time_a, end_ms};

endmodule

>>> hdl/vte_queue.sv
// Short FIFO between the front end and the back end.
`timescale 1ns / 1ps

module vte_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = vte_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/vte_back.sv
// Back end: frame table, append/merge, query scan and result register.
`timescale 1ns / 1ps

module vte_back #(
   parameter int MAX_PHONEMES = vte_pkg::DEF_MAX_PHONEMES,
   parameter int TIME_BITS    = vte_pkg::DEF_TIME_BITS,
   localparam int CMD_W       = vte_pkg::OP_W + vte_pkg::VIS_W + 2 * TIME_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  logic [CMD_W-1:0]              q_data,
   output logic                          q_pop,
   input  logic [vte_pkg::PERIOD_W-1:0]  period,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic [vte_pkg::FIDX_W-1:0]    rsp_frame_index,
   output logic                          rsp_merged,
   output logic [vte_pkg::VIS_W-1:0]     rsp_viseme,
   output logic [vte_pkg::BLEND_W-1:0]   rsp_blend_tenths,
   output logic [vte_pkg::FCOUNT_W-1:0]  rsp_frame_count
);
   import vte_pkg::*;

   localparam int IW    = $clog2(MAX_PHONEMES);
   localparam int CW    = $clog2(MAX_PHONEMES + 1);
   localparam int TB    = TIME_BITS;
   localparam int ENT_W = 2 * TB + VIS_W;

   back_state_type       state_ff, state_in;
   logic [CW-1:0]        frames_ff, frames_in;
   logic [CW-1:0]        taken_ff, taken_in;
   logic [TB-1:0]        last_start_ff, last_start_in;
   logic [TB-1:0]        last_end_ff, last_end_in;
   logic [VIS_W-1:0]     last_vis_ff, last_vis_in;
   logic [TB-1:0]        qtime_ff, qtime_in;
   logic [CW-1:0]        scan_ff, scan_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IW-1:0]        chk_idx_ff, chk_idx_in;
   logic                 res_status_ff, res_status_in;
   logic [IW-1:0]        res_idx_ff, res_idx_in;
   logic                 res_merged_ff, res_merged_in;
   logic [VIS_W-1:0]     res_vis_ff, res_vis_in;
   logic [TB-1:0]        res_start_ff, res_start_in;
   logic [TB-1:0]        res_end_ff, res_end_in;
   logic                 res_blend_ok_ff, res_blend_ok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_status_ff, rsp_status_in;
   logic [FIDX_W-1:0]    rsp_frame_index_ff, rsp_frame_index_in;
   logic                 rsp_merged_ff, rsp_merged_in;
   logic [VIS_W-1:0]     rsp_viseme_ff, rsp_viseme_in;
   logic [BLEND_W-1:0]   rsp_blend_ff, rsp_blend_in;
   logic [FCOUNT_W-1:0]  rsp_frame_count_ff, rsp_frame_count_in;

   op_type               cmd_op;
   logic [VIS_W-1:0]     cmd_vis;
   logic [TB-1:0]        cmd_ta;
   logic [TB-1:0]        cmd_tb;

   logic                 ram_wr_en;
   logic [IW-1:0]        ram_wr_addr;
   logic [ENT_W-1:0]     ram_wr_data;
   logic                 ram_rd_en;
   logic [ENT_W-1:0]     ram_rd_data;
   logic [TB-1:0]        rd_start;
   logic [TB-1:0]        rd_end;
   logic [VIS_W-1:0]     rd_vis;

   logic [CW-1:0]        last_pos;
   logic                 table_full;
   logic                 do_merge;
   logic [CW-1:0]        add_pos;
   logic [TB-1:0]        add_start;
   logic                 hit;
   logic                 last_chk;
   logic                 issue;
   logic                 out_free;
   logic [TB-1:0]        dur;
   logic [BLEND_W-1:0]   blend;

   assign cmd_op  = op_type'(q_data[CMD_W-1 -: OP_W]);
   assign cmd_vis = q_data[2*TB +: VIS_W];
   assign cmd_ta  = q_data[TB +: TB];
   assign cmd_tb  = q_data[0 +: TB];

   assign {rd_start, rd_end, rd_vis} = ram_rd_data;

   assign last_pos   = frames_ff - CW'(1);
   assign table_full = (taken_ff >= CW'(MAX_PHONEMES));
   assign do_merge   = (frames_ff != '0) && (last_vis_ff == cmd_vis);
   assign add_pos    = do_merge ? last_pos : frames_ff;
   assign add_start  = do_merge ? last_start_ff : cmd_ta;

   assign hit      = chk_vld_ff && (qtime_ff >= rd_start) && (qtime_ff < rd_end);
   assign last_chk = chk_vld_ff && (CW'(chk_idx_ff) == last_pos);
   assign issue    = (state_ff == BK_SCAN) && !hit && !last_chk && (scan_ff < frames_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign dur = (res_end_ff > res_start_ff) ? res_end_ff - res_start_ff : TB'(period);
   always_comb begin
      if (!res_blend_ok_ff) begin
         blend = BLEND_NONE;
      end else if (dur < TB'(DUR_SHORT_MS)) begin
         blend = BLEND_SHORT;
      end else if (dur < TB'(DUR_MID_MS)) begin
         blend = BLEND_MID;
      end else begin
         blend = BLEND_LONG;
      end
   end

   assign q_pop       = (state_ff == BK_IDLE) && q_valid;
   assign ram_wr_en   = q_pop && (cmd_op == OP_ADD) && !table_full;
   assign ram_wr_addr = add_pos[IW-1:0];
   assign ram_wr_data = {add_start, cmd_tb, cmd_vis};
   assign ram_rd_en   = issue;

   vte_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_PHONEMES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_ff[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               if (cmd_op == OP_QUERY && frames_ff != '0) begin
                  state_in = BK_SCAN;
               end else begin
                  state_in = BK_EMIT;
               end
            end
         end
         BK_SCAN: begin
            if (hit || last_chk) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      frames_in          = frames_ff;
      taken_in           = taken_ff;
      last_start_in      = last_start_ff;
      last_end_in        = last_end_ff;
      last_vis_in        = last_vis_ff;
      qtime_in           = qtime_ff;
      scan_in            = scan_ff;
      chk_vld_in         = 1'b0;
      chk_idx_in         = chk_idx_ff;
      res_status_in      = res_status_ff;
      res_idx_in         = res_idx_ff;
      res_merged_in      = res_merged_ff;
      res_vis_in         = res_vis_ff;
      res_start_in       = res_start_ff;
      res_end_in         = res_end_ff;
      res_blend_ok_in    = res_blend_ok_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_frame_index_in = rsp_frame_index_ff;
      rsp_merged_in      = rsp_merged_ff;
      rsp_viseme_in      = rsp_viseme_ff;
      rsp_blend_in       = rsp_blend_ff;
      rsp_frame_count_in = rsp_frame_count_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               res_status_in   = 1'b0;
               res_idx_in      = '0;
               res_merged_in   = 1'b0;
               res_vis_in      = VISEME_SIL;
               res_blend_ok_in = 1'b0;
               qtime_in        = cmd_ta;
               scan_in         = '0;
               case (cmd_op)
                  OP_ADD: begin
                     if (table_full) begin
                        res_status_in = 1'b1;
                     end else begin
                        taken_in        = taken_ff + CW'(1);
                        frames_in       = do_merge ? frames_ff : frames_ff + CW'(1);
                        last_start_in   = add_start;
                        last_end_in     = cmd_tb;
                        last_vis_in     = cmd_vis;
                        res_idx_in      = add_pos[IW-1:0];
                        res_merged_in   = do_merge;
                        res_vis_in      = cmd_vis;
                        res_start_in    = add_start;
                        res_end_in      = cmd_tb;
                        res_blend_ok_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     frames_in = '0;
                     taken_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_SCAN: begin
            if (hit) begin
               res_idx_in      = chk_idx_ff;
               res_vis_in      = rd_vis;
               res_start_in    = rd_start;
               res_end_in      = rd_end;
               res_blend_ok_in = 1'b1;
            end else if (last_chk) begin
               if (qtime_ff >= last_end_ff) begin
                  res_idx_in      = last_pos[IW-1:0];
                  res_vis_in      = last_vis_ff;
                  res_start_in    = last_start_ff;
                  res_end_in      = last_end_ff;
                  res_blend_ok_in = 1'b1;
               end
            end else if (issue) begin
               scan_in    = scan_ff + CW'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = scan_ff[IW-1:0];
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_status_in      = res_status_ff;
               rsp_frame_index_in = FIDX_W'(res_idx_ff);
               rsp_merged_in      = res_merged_ff;
               rsp_viseme_in      = res_vis_ff;
               rsp_blend_in       = blend;
               rsp_frame_count_in = FCOUNT_W'(frames_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         frames_ff    <= '0;
         taken_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frames_ff    <= frames_in;
         taken_ff     <= taken_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_start_ff      <= last_start_in;
      last_end_ff        <= last_end_in;
      last_vis_ff        <= last_vis_in;
      qtime_ff           <= qtime_in;
      scan_ff            <= scan_in;
      chk_idx_ff         <= chk_idx_in;
      res_status_ff      <= res_status_in;
      res_idx_ff         <= res_idx_in;
      res_merged_ff      <= res_merged_in;
      res_vis_ff         <= res_vis_in;
      res_start_ff       <= res_start_in;
      res_end_ff         <= res_end_in;
      res_blend_ok_ff    <= res_blend_ok_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_frame_index_ff <= rsp_frame_index_in;
      rsp_merged_ff      <= rsp_merged_in;
      rsp_viseme_ff      <= rsp_viseme_in;
      rsp_blend_ff       <= rsp_blend_in;
      rsp_frame_count_ff <= rsp_frame_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_index  = rsp_frame_index_ff;
   assign rsp_merged       = rsp_merged_ff;
   assign rsp_viseme       = rsp_viseme_ff;
   assign rsp_blend_tenths = rsp_blend_ff;
   assign rsp_frame_count  = rsp_frame_count_ff;

endmodule
